// ===== hw/rtl/gtu_pkg.sv =====
// Shared constants, tables and types for the GNSS time to UTC calendar block.
// Used by gtu_leap_lookup, gnss_time_to_utc_calendar and the testbench; depends on nothing.
package gtu_pkg;

    // Pipeline depth, input register through result register
    localparam int NSTG = 8;

    // Leap second insertion table
    localparam int LEAP_TABLE_SIZE = 18;
    localparam int TABLE_ENTRIES   = 18;
    localparam int LEAP_USED       = (LEAP_TABLE_SIZE < TABLE_ENTRIES) ?
                                     LEAP_TABLE_SIZE : TABLE_ENTRIES;
    localparam int CORR_W          = $clog2(LEAP_USED + 1);

    localparam logic [31:0] LEAP_INSTANTS [TABLE_ENTRIES] = '{
        32'd46828800,  32'd78364801,  32'd109900802,  32'd173059203,
        32'd252028804, 32'd315187205, 32'd346723206,  32'd393984007,
        32'd425520008, 32'd457056009, 32'd504489610,  32'd551750411,
        32'd599184012, 32'd820108813, 32'd914803214,  32'd1025136015,
        32'd1119744016, 32'd1167264017
    };

    // Time system codes
    localparam logic [1:0] TS_GPS = 2'd0;
    localparam logic [1:0] TS_GAL = 2'd1;
    localparam logic [1:0] TS_BDS = 2'd2;

    // Total GPS seconds fit in 33 bits for every input pattern
    localparam int T_W = 33;

    localparam logic [T_W-1:0] SECS_PER_WEEK  = 33'd604800;
    localparam logic [13:0]    GAL_WEEK_SHIFT = 14'd1024;
    localparam logic [13:0]    BDS_WEEK_SHIFT = 14'd1356;
    localparam logic [20:0]    BDS_SEC_SHIFT  = 21'd14;

    // Seconds per day = 2^7 * 675; divide by 675 with a reciprocal
    localparam int          DAY_LO_BITS = 7;
    localparam logic [9:0]  DAY_DIV     = 10'd675;
    localparam int          RECIP_SHIFT = 36;
    localparam logic [26:0] RECIP_675   = 27'd101806632;

    localparam logic [16:0] DAYS_TO_1984   = 17'd1456;
    localparam int          DAYS_PER_CYCLE = 1461;
    localparam int          CYCLES_MAX     = 29;   // first cycle that starts in 2100
    localparam logic [11:0] BASE_YEAR      = 12'd1984;

    localparam int SECS_PER_HOUR = 3600;
    localparam int SECS_PER_MIN  = 60;

    localparam logic [8:0] MONTH_START [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    typedef struct packed {
        logic [CORR_W-1:0] corr;   // leap seconds to remove
        logic              at;     // exactly at an insertion instant
    } t_leap_res;

endpackage

// ===== hw/rtl/gtu_leap_lookup.sv =====
// Leap second lookup: compares a GPS second count against the insertion table.
// Depends on gtu_pkg for the table and the result struct.
module gtu_leap_lookup (
    input  logic [gtu_pkg::T_W-1:0] i_t,
    input  logic                    i_enable,
    output gtu_pkg::t_leap_res      o_res
);

    logic [gtu_pkg::CORR_W-1:0] w_cnt;
    logic                       w_at;

    // Table is ascending, so the count of instants at or below t is the
    // leap count plus one when t sits on an instant.
    always_comb begin
        w_cnt = '0;
        w_at  = 1'b0;
        for (int i = 0; i < gtu_pkg::LEAP_USED; i++) begin
            if (i_t >= {1'b0, gtu_pkg::LEAP_INSTANTS[i]}) begin
                w_cnt = w_cnt + gtu_pkg::CORR_W'(1);
            end
            if (i_t == {1'b0, gtu_pkg::LEAP_INSTANTS[i]}) begin
                w_at = 1'b1;
            end
        end
    end

    assign o_res.corr = i_enable ? w_cnt : '0;
    assign o_res.at   = i_enable & w_at;

endmodule

// ===== hw/rtl/gnss_time_to_utc_calendar.sv =====
// Top level of the GNSS time to UTC calendar converter: eight-stage pipeline.
// Depends on gtu_pkg and gtu_leap_lookup.
//
//  channel | valid    | stall    | word
//  --------+----------+----------+--------------------------------------------
//  input   | i_valid  | o_stall  | time system, week, second of week, fraction
//  output  | o_valid  | i_stall  | year, month, day, h:m:s, fraction, range flag
//  config  | i_cfg_we | -        | i_cfg_data = leap_enable
//
// One word enters per cycle while o_stall is low; each word passes through eight
// register stages, input register to result register. The stages carry the day
// divide (reciprocal multiply, then a correcting multiply) and the compare ladders
// for hour, minute, four-year cycle and month.
// Reset clears the stage valid bits and sets leap_enable to 1.
// A stall only holds the stages that are full; empty stages keep filling.
module gnss_time_to_utc_calendar (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_time_system,
    input  logic [12:0] i_week_number,
    input  logic [19:0] i_second_of_week,
    input  logic [31:0] i_second_fraction,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [11:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day_of_month,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [5:0]  o_second,
    output logic [31:0] o_fraction_out,
    output logic        o_out_of_range
);

    logic                     r_leap_en;
    logic [gtu_pkg::NSTG-1:0] r_vld;
    logic [gtu_pkg::NSTG-1:0] w_rdy;

    // stage 0: input register
    logic [1:0]  r_s0_sys;
    logic [12:0] r_s0_week;
    logic [19:0] r_s0_sow;
    logic [31:0] r_s0_frac;
    // stage 1: total GPS seconds
    logic [gtu_pkg::T_W-1:0] r_s1_t, n_s1_t;
    logic [31:0]             r_s1_frac;
    // stage 2: leap corrected seconds
    logic [gtu_pkg::T_W-1:0] r_s2_u, n_s2_u;
    logic                    r_s2_at;
    logic [31:0]             r_s2_frac;
    // stage 3: day quotient estimate
    logic [16:0]             r_s3_qest, n_s3_qest;
    logic [gtu_pkg::T_W-1:0] r_s3_u;
    logic                    r_s3_at;
    logic [31:0]             r_s3_frac;
    // stage 4: days and second of day
    logic [16:0] r_s4_days, n_s4_days;
    logic [16:0] r_s4_sod, n_s4_sod;
    logic        r_s4_at;
    logic [31:0] r_s4_frac;
    // stage 5: four-year cycle and hour
    logic        r_s5_oor, n_s5_oor;
    logic [4:0]  r_s5_cyc, n_s5_cyc;
    logic [10:0] r_s5_dcyc, n_s5_dcyc;
    logic [4:0]  r_s5_hour, n_s5_hour;
    logic [11:0] r_s5_rem, n_s5_rem;
    logic        r_s5_at;
    logic [31:0] r_s5_frac;
    // stage 6: year, day of year, minute, second
    logic        r_s6_oor;
    logic [11:0] r_s6_year, n_s6_year;
    logic [8:0]  r_s6_doy, n_s6_doy;
    logic        r_s6_feb29, n_s6_feb29;
    logic [4:0]  r_s6_hour;
    logic [5:0]  r_s6_min, n_s6_min;
    logic [5:0]  r_s6_sec, n_s6_sec;
    logic        r_s6_at;
    logic [31:0] r_s6_frac;
    // stage 7: result register
    logic [11:0] r_year, n_year;
    logic [3:0]  r_month, n_month;
    logic [4:0]  r_day, n_day;
    logic [4:0]  r_hour, n_hour;
    logic [5:0]  r_min, n_min;
    logic [5:0]  r_sec, n_sec;
    logic [31:0] r_frac, n_frac;
    logic        r_oor;

    gtu_pkg::t_leap_res w_leap;

    // ---------------- flow control ----------------
    always_comb begin
        w_rdy[gtu_pkg::NSTG-1] = ~r_vld[gtu_pkg::NSTG-1] | ~i_stall;
        for (int k = gtu_pkg::NSTG - 2; k >= 0; k--) begin
            w_rdy[k] = ~r_vld[k] | w_rdy[k+1];
        end
    end

    assign o_stall = ~w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_leap_en <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                r_leap_en <= i_cfg_data;
            end
            if (w_rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < gtu_pkg::NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ---------------- stage 1: move onto GPS time ----------------
    logic [13:0] w_week_adj;
    logic [20:0] w_sow_adj;

    always_comb begin
        w_week_adj = {1'b0, r_s0_week};
        w_sow_adj  = {1'b0, r_s0_sow};
        case (r_s0_sys)
            gtu_pkg::TS_GAL: begin
                w_week_adj = {1'b0, r_s0_week} + gtu_pkg::GAL_WEEK_SHIFT;
            end
            gtu_pkg::TS_BDS: begin
                w_week_adj = {1'b0, r_s0_week} + gtu_pkg::BDS_WEEK_SHIFT;
                w_sow_adj  = {1'b0, r_s0_sow} + gtu_pkg::BDS_SEC_SHIFT;
            end
            default: begin
                // GPS, and the unused code treated as GPS
                w_week_adj = {1'b0, r_s0_week};
            end
        endcase
        n_s1_t = gtu_pkg::T_W'(w_week_adj) * gtu_pkg::SECS_PER_WEEK
               + gtu_pkg::T_W'(w_sow_adj);
    end

    // ---------------- stage 2: leap correction ----------------
    gtu_leap_lookup u_leap (
        .i_t      (r_s1_t),
        .i_enable (r_leap_en),
        .o_res    (w_leap)
    );

    always_comb begin
        if (r_s1_t >= gtu_pkg::T_W'(w_leap.corr)) begin
            n_s2_u = r_s1_t - gtu_pkg::T_W'(w_leap.corr);
        end else begin
            n_s2_u = '0;
        end
    end

    // ---------------- stage 3: estimate u / 86400 ----------------
    logic [25:0] w_s2_x;
    logic [52:0] w_prod;

    assign w_s2_x    = r_s2_u[gtu_pkg::T_W-1:gtu_pkg::DAY_LO_BITS];
    assign w_prod    = 53'(w_s2_x) * 53'(gtu_pkg::RECIP_675);
    // estimate is exact or one low
    assign n_s3_qest = w_prod[gtu_pkg::RECIP_SHIFT +: 17];

    // ---------------- stage 4: correct quotient ----------------
    logic [25:0] w_s3_x;
    logic [26:0] w_qmul;
    logic [26:0] w_rem;

    always_comb begin
        w_s3_x = r_s3_u[gtu_pkg::T_W-1:gtu_pkg::DAY_LO_BITS];
        w_qmul = 27'(r_s3_qest) * 27'(gtu_pkg::DAY_DIV);
        w_rem  = 27'(w_s3_x) - w_qmul;
        if (w_rem >= 27'(gtu_pkg::DAY_DIV)) begin
            n_s4_days = r_s3_qest + 17'd1;
            w_rem     = w_rem - 27'(gtu_pkg::DAY_DIV);
        end else begin
            n_s4_days = r_s3_qest;
        end
        n_s4_sod = {w_rem[9:0], r_s3_u[gtu_pkg::DAY_LO_BITS-1:0]};
    end

    // ---------------- stage 5: cycle ladder, hour ladder ----------------
    logic [16:0] w_days2;
    logic [16:0] w_cyc_base;
    logic [16:0] w_hr_base;

    always_comb begin
        w_days2    = r_s4_days - gtu_pkg::DAYS_TO_1984;
        n_s5_cyc   = '0;
        w_cyc_base = '0;
        for (int k = 1; k <= gtu_pkg::CYCLES_MAX; k++) begin
            if (w_days2 >= 17'(k * gtu_pkg::DAYS_PER_CYCLE)) begin
                n_s5_cyc   = 5'(k);
                w_cyc_base = 17'(k * gtu_pkg::DAYS_PER_CYCLE);
            end
        end
        n_s5_dcyc = 11'(w_days2 - w_cyc_base);
        n_s5_oor  = (r_s4_days < gtu_pkg::DAYS_TO_1984) ||
                    (n_s5_cyc == 5'(gtu_pkg::CYCLES_MAX));

        n_s5_hour = '0;
        w_hr_base = '0;
        for (int k = 1; k < 24; k++) begin
            if (r_s4_sod >= 17'(k * gtu_pkg::SECS_PER_HOUR)) begin
                n_s5_hour = 5'(k);
                w_hr_base = 17'(k * gtu_pkg::SECS_PER_HOUR);
            end
        end
        n_s5_rem = 12'(r_s4_sod - w_hr_base);
    end

    // ---------------- stage 6: year in cycle, minute ladder ----------------
    logic [1:0]  w_yoff;
    logic [11:0] w_min_base;

    always_comb begin
        n_s6_feb29 = 1'b0;
        if (r_s5_dcyc >= 11'd1096) begin
            w_yoff   = 2'd3;
            n_s6_doy = 9'(r_s5_dcyc - 11'd1096);
        end else if (r_s5_dcyc >= 11'd731) begin
            w_yoff   = 2'd2;
            n_s6_doy = 9'(r_s5_dcyc - 11'd731);
        end else if (r_s5_dcyc >= 11'd366) begin
            w_yoff   = 2'd1;
            n_s6_doy = 9'(r_s5_dcyc - 11'd366);
        end else if (r_s5_dcyc >= 11'd60) begin
            // leap year past Feb 29: fold onto the common-year table
            w_yoff   = 2'd0;
            n_s6_doy = 9'(r_s5_dcyc - 11'd1);
        end else begin
            w_yoff     = 2'd0;
            n_s6_doy   = 9'(r_s5_dcyc);
            n_s6_feb29 = (r_s5_dcyc == 11'd59);
        end
        n_s6_year = gtu_pkg::BASE_YEAR + 12'({r_s5_cyc, w_yoff});

        n_s6_min   = '0;
        w_min_base = '0;
        for (int k = 1; k < 60; k++) begin
            if (r_s5_rem >= 12'(k * gtu_pkg::SECS_PER_MIN)) begin
                n_s6_min   = 6'(k);
                w_min_base = 12'(k * gtu_pkg::SECS_PER_MIN);
            end
        end
        n_s6_sec = 6'(r_s5_rem - w_min_base);
    end

    // ---------------- stage 7: month ladder, result ----------------
    logic [3:0] w_mon;
    logic [8:0] w_mon_base;

    always_comb begin
        w_mon      = 4'd1;
        w_mon_base = gtu_pkg::MONTH_START[0];
        for (int k = 1; k < 12; k++) begin
            if (r_s6_doy >= gtu_pkg::MONTH_START[k]) begin
                w_mon      = 4'(k + 1);
                w_mon_base = gtu_pkg::MONTH_START[k];
            end
        end
        if (r_s6_oor) begin
            // drop everything but the flag
            n_year  = '0;
            n_month = '0;
            n_day   = '0;
            n_hour  = '0;
            n_min   = '0;
            n_sec   = '0;
            n_frac  = '0;
        end else begin
            n_year = r_s6_year;
            if (r_s6_feb29) begin
                n_month = 4'd2;
                n_day   = 5'd29;
            end else begin
                n_month = w_mon;
                n_day   = 5'(r_s6_doy - w_mon_base + 9'd1);
            end
            n_hour = r_s6_hour;
            n_min  = r_s6_min;
            n_sec  = r_s6_sec + {5'd0, r_s6_at};
            n_frac = r_s6_frac;
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_s0_sys  <= i_time_system;
            r_s0_week <= i_week_number;
            r_s0_sow  <= i_second_of_week;
            r_s0_frac <= i_second_fraction;
        end
        if (w_rdy[1]) begin
            r_s1_t    <= n_s1_t;
            r_s1_frac <= r_s0_frac;
        end
        if (w_rdy[2]) begin
            r_s2_u    <= n_s2_u;
            r_s2_at   <= w_leap.at;
            r_s2_frac <= r_s1_frac;
        end
        if (w_rdy[3]) begin
            r_s3_qest <= n_s3_qest;
            r_s3_u    <= r_s2_u;
            r_s3_at   <= r_s2_at;
            r_s3_frac <= r_s2_frac;
        end
        if (w_rdy[4]) begin
            r_s4_days <= n_s4_days;
            r_s4_sod  <= n_s4_sod;
            r_s4_at   <= r_s3_at;
            r_s4_frac <= r_s3_frac;
        end
        if (w_rdy[5]) begin
            r_s5_oor  <= n_s5_oor;
            r_s5_cyc  <= n_s5_cyc;
            r_s5_dcyc <= n_s5_dcyc;
            r_s5_hour <= n_s5_hour;
            r_s5_rem  <= n_s5_rem;
            r_s5_at   <= r_s4_at;
            r_s5_frac <= r_s4_frac;
        end
        if (w_rdy[6]) begin
            r_s6_oor   <= r_s5_oor;
            r_s6_year  <= n_s6_year;
            r_s6_doy   <= n_s6_doy;
            r_s6_feb29 <= n_s6_feb29;
            r_s6_hour  <= r_s5_hour;
            r_s6_min   <= n_s6_min;
            r_s6_sec   <= n_s6_sec;
            r_s6_at    <= r_s5_at;
            r_s6_frac  <= r_s5_frac;
        end
        if (w_rdy[7]) begin
            r_year  <= n_year;
            r_month <= n_month;
            r_day   <= n_day;
            r_hour  <= n_hour;
            r_min   <= n_min;
            r_sec   <= n_sec;
            r_frac  <= n_frac;
            r_oor   <= r_s6_oor;
        end
    end

    assign o_valid        = r_vld[gtu_pkg::NSTG-1];
    assign o_year         = r_year;
    assign o_month        = r_month;
    assign o_day_of_month = r_day;
    assign o_hour         = r_hour;
    assign o_minute       = r_min;
    assign o_second       = r_sec;
    assign o_fraction_out = r_frac;
    assign o_out_of_range = r_oor;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for gnss_time_to_utc_calendar: random and directed GNSS time words
// go in, and each UTC calendar word that comes out is checked against a behavioral predictor.
// Depends on gtu_pkg for the time system codes and on the block's RTL.
`timescale 1ns / 100ps

module testbench;

    localparam logic [1:0] TS_SPARE = 2'd3;   // unused code, handled as GPS

    localparam longint unsigned WEEK_SECS        = 604800;
    localparam longint unsigned DAY_SECS         = 86400;
    localparam longint unsigned GAL_WEEKS        = 1024;
    localparam longint unsigned BDS_WEEKS        = 1356;
    localparam longint unsigned BDS_SECS         = 14;
    localparam longint unsigned DAYS_BEFORE_1984 = 208 * 7;
    localparam longint unsigned LEAP_YEAR_DAYS   = 366;
    localparam longint unsigned YEAR_DAYS        = 365;
    localparam longint unsigned CYCLE_DAYS       = 366 + 365 * 3;
    localparam longint unsigned FIRST_YEAR       = 1984;
    localparam longint unsigned LAST_YEAR        = 2099;
    localparam int              LEAP_COUNT       = 18;

    // GPS seconds of 1984-01-01 00:00:00 and of 2099-12-31 23:59:59, leap seconds included
    localparam int unsigned T_LO = 125798403;
    localparam int unsigned T_HI = 3786480017;
    localparam longint unsigned DAY_LO = DAYS_BEFORE_1984;
    localparam longint unsigned DAY_HI = DAYS_BEFORE_1984 + 29 * CYCLE_DAYS;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int MAX_PRINTS     = 100;

    localparam logic [31:0] LEAP_AT [LEAP_COUNT] = '{
        32'd46828800,  32'd78364801,  32'd109900802, 32'd173059203,
        32'd252028804, 32'd315187205, 32'd346723206, 32'd393984007,
        32'd425520008, 32'd457056009, 32'd504489610, 32'd551750411,
        32'd599184012, 32'd820108813, 32'd914803214, 32'd1025136015,
        32'd1119744016, 32'd1167264017
    };

    localparam logic [8:0] MONTH_DAYS [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    // Day offsets inside a four-year cycle around year ends and February
    localparam logic [10:0] CYCLE_MARKS [13] = '{
        11'd0, 11'd58, 11'd59, 11'd60, 11'd365, 11'd366, 11'd424,
        11'd425, 11'd730, 11'd731, 11'd1095, 11'd1096, 11'd1460
    };

    typedef struct packed {
        logic [1:0]  sys;
        logic [12:0] week;
        logic [19:0] sow;
        logic [31:0] frac;
    } t_gnss_word;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  mday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [31:0] frac;
        logic        oor;
    } t_utc_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_data = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_time_system = '0;
    logic [12:0] i_week_number = '0;
    logic [19:0] i_second_of_week = '0;
    logic [31:0] i_second_fraction = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [11:0] o_year;
    logic [3:0]  o_month;
    logic [4:0]  o_day_of_month;
    logic [4:0]  o_hour;
    logic [5:0]  o_minute;
    logic [5:0]  o_second;
    logic [31:0] o_fraction_out;
    logic        o_out_of_range;

    t_gnss_word gnss_feed [$];
    t_utc_word  utc_due [$];

    bit          leap_on = 1'b1;
    bit          calm = 1'b0;
    int unsigned feed_odds = 0;
    int unsigned stall_odds = 0;
    int unsigned feed_gap = 0;
    int unsigned stall_left = 0;
    int unsigned n_sent = 0;
    int unsigned n_taken = 0;
    int unsigned n_results = 0;
    int unsigned err_count = 0;

    gnss_time_to_utc_calendar i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_time_system     (i_time_system),
        .i_week_number     (i_week_number),
        .i_second_of_week  (i_second_of_week),
        .i_second_fraction (i_second_fraction),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_year            (o_year),
        .o_month           (o_month),
        .o_day_of_month    (o_day_of_month),
        .o_hour            (o_hour),
        .o_minute          (o_minute),
        .o_second          (o_second),
        .o_fraction_out    (o_fraction_out),
        .o_out_of_range    (o_out_of_range)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // UTC calendar word for one GNSS time word
    function automatic t_utc_word utc_from_gnss(t_gnss_word w, bit leap_on_now);
        t_utc_word       r;
        longint unsigned wk, t, u, days, corr, sod, d, yr;
        int unsigned     mon;
        bit              at_ins, found;
        r = '0;
        wk = 64'(w.week);
        t = 64'(w.sow);
        corr = 0;
        at_ins = 1'b0;
        found = 1'b0;
        if (w.sys == gtu_pkg::TS_GAL) begin
            wk = wk + GAL_WEEKS;
        end else if (w.sys == gtu_pkg::TS_BDS) begin
            wk = wk + BDS_WEEKS;
            t = t + BDS_SECS;
        end
        t = t + wk * WEEK_SECS;
        if (leap_on_now) begin
            corr = 64'(LEAP_COUNT);
            for (int k = 0; k < LEAP_COUNT; k++) begin
                if (!found && t <= 64'(LEAP_AT[k])) begin
                    found = 1'b1;
                    corr = 64'(k);
                    at_ins = (t == 64'(LEAP_AT[k]));
                end
            end
            if (at_ins)
                corr++;
        end
        u = (t >= corr) ? t - corr : 64'd0;
        days = u / DAY_SECS;
        sod = u % DAY_SECS;
        if (days < DAYS_BEFORE_1984) begin
            r.oor = 1'b1;
            return r;
        end
        days = days - DAYS_BEFORE_1984;
        yr = FIRST_YEAR + 4 * (days / CYCLE_DAYS);
        d = days % CYCLE_DAYS;
        // first year of each cycle is the leap year; d == 59 is February 29
        if (d >= LEAP_YEAR_DAYS + 2 * YEAR_DAYS) begin
            d = d - (LEAP_YEAR_DAYS + 2 * YEAR_DAYS);
            yr = yr + 3;
        end else if (d >= LEAP_YEAR_DAYS + YEAR_DAYS) begin
            d = d - (LEAP_YEAR_DAYS + YEAR_DAYS);
            yr = yr + 2;
        end else if (d >= LEAP_YEAR_DAYS) begin
            d = d - LEAP_YEAR_DAYS;
            yr = yr + 1;
        end else if (d >= 60) begin
            d = d - 1;
        end else if (d == 59) begin
            d = 1000;   // marker for the leap day
        end
        if (yr > LAST_YEAR) begin
            r.oor = 1'b1;
            return r;
        end
        if (d == 1000) begin
            mon = 2;
            d = 28 + 64'(MONTH_DAYS[1]);
        end else begin
            mon = 12;
            for (int k = 11; k >= 1; k--) begin
                if (d < 64'(MONTH_DAYS[k]))
                    mon = k;
            end
        end
        r.year = 12'(yr);
        r.month = 4'(mon);
        r.mday = 5'(d - 64'(MONTH_DAYS[mon - 1]) + 1);
        r.hour = 5'(sod / 3600);
        r.minute = 6'((sod % 3600) / 60);
        r.second = 6'((sod % 60) + 64'(at_ins));
        r.frac = w.frac;
        return r;
    endfunction

    // Express a GPS second count in the chosen time system, GPS when it predates that system
    function automatic t_gnss_word gnss_from_gps(longint unsigned t, logic [1:0] sys);
        t_gnss_word      w;
        longint unsigned base;
        base = 0;
        if (sys == gtu_pkg::TS_GAL)
            base = GAL_WEEKS * WEEK_SECS;
        else if (sys == gtu_pkg::TS_BDS)
            base = BDS_WEEKS * WEEK_SECS + BDS_SECS;
        if (t < base) begin
            sys = gtu_pkg::TS_GPS;
            base = 0;
        end
        w.sys = sys;
        w.week = 13'((t - base) / WEEK_SECS);
        w.sow = 20'((t - base) % WEEK_SECS);
        w.frac = $urandom;
        return w;
    endfunction

    function automatic t_gnss_word gnss_random();
        t_gnss_word      w;
        int unsigned     pick;
        logic [1:0]      sys;
        longint unsigned t;
        pick = $urandom_range(0, 99);
        sys = 2'($urandom_range(0, 3));
        if (pick < 35) begin
            w = gnss_from_gps(64'($urandom_range(T_HI, T_LO)), sys);
        end else if (pick < 55) begin
            t = 64'(LEAP_AT[5'($urandom_range(0, LEAP_COUNT - 1))]);
            t = t + 64'($urandom_range(0, 4)) - 2;
            w = gnss_from_gps(t, sys);
        end else if (pick < 70) begin
            if (pick < 63) begin
                t = 64'($urandom_range(32'(DAY_HI), 32'(DAY_LO)));
            end else begin
                t = 64'($urandom_range(0, 28));
                t = DAY_LO + t * CYCLE_DAYS + 64'(CYCLE_MARKS[4'($urandom_range(0, 12))]);
            end
            // straddle midnight whatever the leap count is
            t = t * DAY_SECS + 64'($urandom_range(0, 40));
            w = gnss_from_gps(t, sys);
        end else if (pick < 85) begin
            w.sys = 2'($urandom);
            w.week = 13'($urandom);
            w.sow = 20'($urandom);
            w.frac = $urandom;
        end else begin
            w.sys = sys;
            w.week = 13'($urandom_range(0, 8191));
            w.sow = 20'($urandom_range(0, 604799));
            w.frac = $urandom;
        end
        return w;
    endfunction

    task automatic push_word(logic [1:0] sys, logic [12:0] week, logic [19:0] sow,
                             logic [31:0] frac);
        t_gnss_word w;
        w.sys = sys;
        w.week = week;
        w.sow = sow;
        w.frac = frac;
        gnss_feed.push_back(w);
    endtask

    task automatic report_error(string msg);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("%0t: result %0d: %s", $time, n_results, msg);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_error($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    task automatic wait_idle();
        while (gnss_feed.size() != 0 || n_taken != n_sent || utc_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_leap(bit v);
        wait_idle();
        @(negedge i_clk);
        i_cfg_data <= v;
        i_cfg_we <= 1'b1;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        leap_on = v;
    endtask

    // Input driver: hold the word until taken, then advance or idle
    always @(negedge i_clk) begin : feed_drv
        t_gnss_word w;
        if (i_rst_n && n_taken == n_sent) begin
            if (feed_gap != 0) begin
                feed_gap--;
                i_valid <= 1'b0;
            end else if (gnss_feed.size() != 0) begin
                w = gnss_feed.pop_front();
                i_time_system <= w.sys;
                i_week_number <= w.week;
                i_second_of_week <= w.sow;
                i_second_fraction <= w.frac;
                i_valid <= 1'b1;
                n_sent++;
                if (!calm && feed_odds != 0 && $urandom_range(0, feed_odds) == 0)
                    feed_gap = $urandom_range(1, 12);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : stall_drv
        if (!i_rst_n || calm) begin
            i_stall <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (stall_odds != 0 && $urandom_range(0, stall_odds) == 0) begin
            stall_left = $urandom_range(0, 11);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Monitor: predict on every accepted input word, check every accepted result word
    always @(posedge i_clk) begin : word_mon
        t_gnss_word in_w;
        t_utc_word  want;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                in_w = {i_time_system, i_week_number, i_second_of_week, i_second_fraction};
                utc_due.push_back(utc_from_gnss(in_w, leap_on));
                n_taken++;
            end
            if (o_valid && !i_stall) begin
                if (utc_due.size() == 0) begin
                    report_error("result word with nothing expected");
                end else begin
                    want = utc_due.pop_front();
                    check_field("year", 32'(o_year), 32'(want.year));
                    check_field("month", 32'(o_month), 32'(want.month));
                    check_field("day_of_month", 32'(o_day_of_month), 32'(want.mday));
                    check_field("hour", 32'(o_hour), 32'(want.hour));
                    check_field("minute", 32'(o_minute), 32'(want.minute));
                    check_field("second", 32'(o_second), 32'(want.second));
                    check_field("fraction_out", o_fraction_out, want.frac);
                    check_field("out_of_range", 32'(o_out_of_range), 32'(want.oor));
                end
                n_results++;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("testbench: done, errors");
        $finish;
    end

    initial begin : main
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words, leap correction on from reset
        feed_odds = 4;
        stall_odds = 4;
        push_word(gtu_pkg::TS_GPS, 13'd0, 20'd0, 32'd0);
        push_word(gtu_pkg::TS_GPS, 13'd207, 20'd604799, 32'hFFFF_FFFF);
        gnss_feed.push_back(gnss_from_gps(64'(T_LO) - 1, gtu_pkg::TS_GPS));
        gnss_feed.push_back(gnss_from_gps(64'(T_LO), gtu_pkg::TS_GPS));
        gnss_feed.push_back(gnss_from_gps(64'(T_LO) + 59 * DAY_SECS - 1, gtu_pkg::TS_GPS));
        gnss_feed.push_back(gnss_from_gps(64'(T_LO) + 59 * DAY_SECS, gtu_pkg::TS_GPS));
        gnss_feed.push_back(gnss_from_gps(64'(T_LO) + 60 * DAY_SECS, gtu_pkg::TS_GPS));
        gnss_feed.push_back(gnss_from_gps(64'(LEAP_AT[0]), gtu_pkg::TS_GPS));
        gnss_feed.push_back(gnss_from_gps(64'(LEAP_AT[12]), gtu_pkg::TS_GPS));
        gnss_feed.push_back(gnss_from_gps(64'(LEAP_AT[17]) - 1, gtu_pkg::TS_GPS));
        gnss_feed.push_back(gnss_from_gps(64'(LEAP_AT[17]), gtu_pkg::TS_GPS));
        gnss_feed.push_back(gnss_from_gps(64'(LEAP_AT[17]) + 1, gtu_pkg::TS_GPS));
        gnss_feed.push_back(gnss_from_gps(64'(LEAP_AT[17]), gtu_pkg::TS_GAL));
        gnss_feed.push_back(gnss_from_gps(64'(LEAP_AT[17]), gtu_pkg::TS_BDS));
        gnss_feed.push_back(gnss_from_gps(64'(LEAP_AT[17]), TS_SPARE));
        gnss_feed.push_back(gnss_from_gps(64'd2000000000, gtu_pkg::TS_GPS));
        gnss_feed.push_back(gnss_from_gps(64'(T_HI), gtu_pkg::TS_GPS));
        gnss_feed.push_back(gnss_from_gps(64'(T_HI) + 1, gtu_pkg::TS_GPS));
        push_word(gtu_pkg::TS_BDS, 13'd0, 20'd0, 32'hFFFF_FFFF);
        push_word(gtu_pkg::TS_GAL, 13'd8191, 20'd0, 32'h8000_0001);
        push_word(gtu_pkg::TS_BDS, 13'd8191, 20'hFFFFF, 32'hFFFF_FFFF);
        push_word(TS_SPARE, 13'd8191, 20'hFFFFF, 32'h5555_AAAA);
        push_word(gtu_pkg::TS_GPS, 13'd1000, 20'hFFFFF, 32'hFFFF_FFFF);

        set_leap(1'b0);
        feed_odds = 2;
        stall_odds = 2;
        repeat (250) gnss_feed.push_back(gnss_random());

        // no idling on either side here
        set_leap(1'b1);
        feed_odds = 0;
        stall_odds = 0;
        repeat (250) gnss_feed.push_back(gnss_random());

        set_leap(1'b0);
        feed_odds = 6;
        stall_odds = 3;
        repeat (150) gnss_feed.push_back(gnss_random());

        set_leap(1'b1);
        calm = 1'b1;
        repeat (250) gnss_feed.push_back(gnss_random());

        wait_idle();
        if (err_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
